@@ sv/mecanum_field_oriented_mixer_macros.svh @@
// Assertion macros for the mecanum field-oriented mixer.
// No dependencies; included by files that carry concurrent checks.
`ifndef MECANUM_FIELD_ORIENTED_MIXER_MACROS_SVH
`define MECANUM_FIELD_ORIENTED_MIXER_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define MFOM_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mfom: implication check failed");

// Next-cycle implication, disabled while reset is high.
`define MFOM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mfom: next-cycle check failed");

`endif

@@ sv/mfom_pkg.sv @@
// Package for the mecanum field-oriented mixer: constants, stage types and
// the quarter-wave sine table built at elaboration. No dependencies.
package mfom_pkg;

   localparam int SINE_TABLE_ENTRIES = 1024;
   localparam int IDX_W = $clog2(SINE_TABLE_ENTRIES + 1);
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam logic [14:0] LIMIT_RESET = 15'd400;

   // CSR map: one register, byte address 0
   localparam int CSR_ADDR_W = 3;
   localparam logic CSR_IDX_LIMIT = 1'b0;

   typedef logic [14:0] sine_tab_type [SINE_TABLE_ENTRIES + 1];

   // truncating divide by shift and subtract; only run while the table is built
   function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
      logic [63:0] quo;
      logic [64:0] rem;
      quo = '0;
      rem = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[63:0], num[b]};
         if (rem >= {1'b0, den}) begin
            rem    = rem - {1'b0, den};
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   // Q1.15 quarter-wave sine, Taylor series to x^17 in Q2.30
   function automatic sine_tab_type build_sine_tab();
      sine_tab_type tab;
      logic [63:0] x;
      logic [63:0] t;
      logic signed [63:0] s;
      logic [63:0] e;
      for (int k = 0; k <= SINE_TABLE_ENTRIES; k++) begin
         x = (64'(k) * HALF_PI_Q30) / 64'(SINE_TABLE_ENTRIES);
         t = x;
         s = $signed(x);
         for (int n = 1; n <= 8; n++) begin
            t = (t * x) >> 30;
            t = (t * x) >> 30;
            t = udiv64(t, 64'(2 * n) * 64'(2 * n + 1));
            if (n % 2 == 1) begin
               s = s - $signed(t);
            end else begin
               s = s + $signed(t);
            end
         end
         if (s < 0) begin
            s = 64'sd0;
         end
         e = ($unsigned(s) * 64'd32767 + (64'd1 << 29)) >> 30;
         if (e > 64'd32767) begin
            e = 64'd32767;
         end
         tab[k] = e[14:0];
      end
      return tab;
   endfunction

   localparam sine_tab_type SINE_TAB = build_sine_tab();

   typedef struct packed {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [15:0] z;
      logic [15:0]        angle;
   } in_stage_type;

   typedef struct packed {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [15:0] z;
      logic [1:0]         quad;
      logic [14:0]        tab_a;   // T[idx]
      logic [14:0]        tab_b;   // T[N-idx]
   } lut_stage_type;

   typedef struct packed {
      logic signed [31:0] p_xc;
      logic signed [31:0] p_ys;
      logic signed [31:0] p_xs;
      logic signed [31:0] p_yc;
      logic signed [15:0] z;
   } mul_stage_type;

   typedef struct packed {
      logic signed [17:0] xr;
      logic signed [17:0] yr;
      logic signed [15:0] z;
   } rot_stage_type;

   typedef struct packed {
      logic signed [15:0] rear_right;
      logic signed [15:0] front_right;
      logic signed [15:0] front_left;
      logic signed [15:0] rear_left;
      logic [3:0]         mask;
   } out_stage_type;

endpackage

@@ sv/mecanum_field_oriented_mixer.sv @@
// Mecanum field-oriented mixer: heading rotation, wheel mix and clamp.
// Depends on mfom_pkg and mecanum_field_oriented_mixer_macros.svh.
`include "mecanum_field_oriented_mixer_macros.svh"

// Usage
// - Command channel: a beat is taken at a rising edge with start high and
//   busy low. busy is low except during reset, so one beat per cycle.
// - Result channel: rsp_valid pulses for one cycle with the four wheel
//   speeds and the clamp mask. The receiver cannot stall; every result is
//   taken at the edge ending its cycle.
// - Throughput: 1 beat per cycle through the 5-stage pipeline
//   (input reg, sine lookup, multiply, rotate/round, mix/clamp).
// - Config: APB-style, wheel_speed_limit at byte address 0, writes in
//   setup + access cycles, pready tied high. Change it only when idle.
// - Reset (synchronous, high): pipeline valids cleared, limit back to 400.
//   No clearing pass; the sine table is a constant ROM.
module mecanum_field_oriented_mixer
   import mfom_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // command channel
   input  logic                  start,
   output logic                  busy,
   input  logic signed [15:0]    req_target_x_speed,
   input  logic signed [15:0]    req_target_y_speed,
   input  logic signed [15:0]    req_target_turn_speed,
   input  logic signed [15:0]    req_heading_angle,
   // result channel
   output logic                  rsp_valid,
   output logic signed [15:0]    rsp_speed_rear_right,
   output logic signed [15:0]    rsp_speed_front_right,
   output logic signed [15:0]    rsp_speed_front_left,
   output logic signed [15:0]    rsp_speed_rear_left,
   output logic [3:0]            rsp_clamp_mask,
   // config port
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   logic req_accept;
   logic csr_write;

   logic [14:0] limit_ff, limit_in;

   logic          s1_valid_ff, s1_valid_in;
   in_stage_type  s1_ff, s1_in;
   logic          s2_valid_ff, s2_valid_in;
   lut_stage_type s2_ff, s2_in;
   logic          s3_valid_ff, s3_valid_in;
   mul_stage_type s3_ff, s3_in;
   logic          s4_valid_ff, s4_valid_in;
   rot_stage_type s4_ff, s4_in;
   logic          s5_valid_ff, s5_valid_in;
   out_stage_type s5_ff, s5_in;

   // stage 2 address math
   logic [31:0]      frac_scaled;
   logic [IDX_W-1:0] idx_a;
   logic [IDX_W-1:0] idx_b;

   // stage 3 operands
   logic [14:0]        sin_mag;
   logic [14:0]        cos_mag;
   logic signed [15:0] sin_val;
   logic signed [15:0] cos_val;

   // stage 4 sums before rounding
   logic signed [32:0] sum_x;
   logic signed [32:0] sum_y;

   // stage 5 wheel sums
   logic signed [19:0] wheel_sum [4];
   logic signed [19:0] lim_pos;
   logic signed [19:0] lim_neg;
   logic signed [15:0] lim16;
   logic signed [15:0] nlim16;
   logic [3:0]         clamp_bits;
   logic signed [15:0] wheel_out [4];

   assign busy       = reset;
   assign req_accept = start && !busy;

   // ---------------- config port ----------------
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      limit_in = limit_ff;
      if (csr_write && paddr[2] == CSR_IDX_LIMIT) begin
         limit_in = pwdata[14:0];
      end
   end

   always_comb begin
      prdata = 32'd0;
      if (paddr[2] == CSR_IDX_LIMIT) begin
         prdata = {17'd0, limit_ff};
      end
   end

   // ---------------- stage 1: input register ----------------
   assign s1_valid_in = req_accept;
   always_comb begin
      s1_in.x     = req_target_x_speed;
      s1_in.y     = req_target_y_speed;
      s1_in.z     = req_target_turn_speed;
      s1_in.angle = req_heading_angle;
   end

   // ---------------- stage 2: sine ROM lookup ----------------
   // Same fractional index serves sin and cos; cos is a quarter turn ahead,
   // so both only need T[idx] and T[N-idx].
   assign frac_scaled = 32'(s1_ff.angle[13:0]) * 32'(SINE_TABLE_ENTRIES);
   assign idx_a       = frac_scaled[IDX_W+13:14];
   assign idx_b       = IDX_W'(SINE_TABLE_ENTRIES) - idx_a;

   assign s2_valid_in = s1_valid_ff;
   always_comb begin
      s2_in.x     = s1_ff.x;
      s2_in.y     = s1_ff.y;
      s2_in.z     = s1_ff.z;
      s2_in.quad  = s1_ff.angle[15:14];
      s2_in.tab_a = SINE_TAB[idx_a];
      s2_in.tab_b = SINE_TAB[idx_b];
   end

   // ---------------- stage 3: quadrant fold and products ----------------
   // sin: quads 0..3 -> +A, +B, -A, -B.  cos: +B, -A, -B, +A.
   assign sin_mag = s2_ff.quad[0] ? s2_ff.tab_b : s2_ff.tab_a;
   assign cos_mag = s2_ff.quad[0] ? s2_ff.tab_a : s2_ff.tab_b;
   assign sin_val = s2_ff.quad[1] ? -$signed({1'b0, sin_mag}) : $signed({1'b0, sin_mag});
   assign cos_val = (s2_ff.quad[1] ^ s2_ff.quad[0]) ? -$signed({1'b0, cos_mag})
                                                     : $signed({1'b0, cos_mag});

   assign s3_valid_in = s2_valid_ff;
   always_comb begin
      s3_in.p_xc = 32'(s2_ff.x) * 32'(cos_val);
      s3_in.p_ys = 32'(s2_ff.y) * 32'(sin_val);
      s3_in.p_xs = 32'(s2_ff.x) * 32'(sin_val);
      s3_in.p_yc = 32'(s2_ff.y) * 32'(cos_val);
      s3_in.z    = s2_ff.z;
   end

   // ---------------- stage 4: rotate and round Q15 ----------------
   // Rounding is half toward +inf: add 2^14, then floor (arith shift).
   assign sum_x = 33'(s3_ff.p_xc) + 33'(s3_ff.p_ys) + 33'sd16384;
   assign sum_y = 33'(s3_ff.p_yc) - 33'(s3_ff.p_xs) + 33'sd16384;

   assign s4_valid_in = s3_valid_ff;
   always_comb begin
      s4_in.xr = sum_x[32:15];
      s4_in.yr = sum_y[32:15];
      s4_in.z  = s3_ff.z;
   end

   // ---------------- stage 5: wheel mix and clamp ----------------
   assign lim16   = $signed({1'b0, limit_ff});
   assign nlim16  = -lim16;
   assign lim_pos = 20'(lim16);
   assign lim_neg = -lim_pos;

   assign wheel_sum[0] = -20'(s4_ff.xr) - 20'(s4_ff.yr) + 20'(s4_ff.z);
   assign wheel_sum[1] = -20'(s4_ff.xr) + 20'(s4_ff.yr) + 20'(s4_ff.z);
   assign wheel_sum[2] =  20'(s4_ff.xr) + 20'(s4_ff.yr) + 20'(s4_ff.z);
   assign wheel_sum[3] =  20'(s4_ff.xr) - 20'(s4_ff.yr) + 20'(s4_ff.z);

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         if (wheel_sum[i] > lim_pos) begin
            wheel_out[i]  = lim16;
            clamp_bits[i] = 1'b1;
         end else if (wheel_sum[i] < lim_neg) begin
            wheel_out[i]  = nlim16;
            clamp_bits[i] = 1'b1;
         end else begin
            wheel_out[i]  = wheel_sum[i][15:0];
            clamp_bits[i] = 1'b0;
         end
      end
   end

   assign s5_valid_in = s4_valid_ff;
   always_comb begin
      s5_in.rear_right  = wheel_out[0];
      s5_in.front_right = wheel_out[1];
      s5_in.front_left  = wheel_out[2];
      s5_in.rear_left   = wheel_out[3];
      s5_in.mask        = clamp_bits;
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff    <= LIMIT_RESET;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else begin
         limit_ff    <= limit_in;
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
         s4_valid_ff <= s4_valid_in;
         s5_valid_ff <= s5_valid_in;
      end
   end

   // payload carries no reset
   always_ff @(posedge clock) begin
      s1_ff <= s1_in;
      s2_ff <= s2_in;
      s3_ff <= s3_in;
      s4_ff <= s4_in;
      s5_ff <= s5_in;
   end

   assign rsp_valid             = s5_valid_ff;
   assign rsp_speed_rear_right  = s5_ff.rear_right;
   assign rsp_speed_front_right = s5_ff.front_right;
   assign rsp_speed_front_left  = s5_ff.front_left;
   assign rsp_speed_rear_left   = s5_ff.rear_left;
   assign rsp_clamp_mask        = s5_ff.mask;

   // ---------------- checks ----------------
   `MFOM_ASSERT_NEXT(a_beat_latency, clock, reset, req_accept, ##4 rsp_valid)
   `MFOM_ASSERT_IMPLY(a_no_phantom, clock, reset, rsp_valid, $past(req_accept, 5))
   `MFOM_ASSERT_IMPLY(a_rr_in_range, clock, reset, rsp_valid, rsp_speed_rear_right <= lim16 && rsp_speed_rear_right >= nlim16)
   `MFOM_ASSERT_IMPLY(a_fl_clamp_at_limit, clock, reset, rsp_valid && rsp_clamp_mask[2], rsp_speed_front_left == lim16 || rsp_speed_front_left == nlim16)

endmodule
